/* hdl/plbt_pkg.sv */
// shared types and constants for the price level bitmap best tracker
package plbt_pkg;

  // width of a price level field on the ports
  localparam int LEVEL_W = 11;

  // default geometry of the occupancy bitmaps
  localparam int DEF_LEVELS    = 2048;
  localparam int DEF_WORD_BITS = 64;

  // event kinds
  localparam logic KIND_SET   = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  // book sides
  localparam logic SIDE_BID = 1'b0;
  localparam logic SIDE_ASK = 1'b1;

  // one input transaction
  typedef struct packed {
    logic               kind;
    logic               side;
    logic [LEVEL_W-1:0] level_index;
  } in_t;

  // one result transaction
  typedef struct packed {
    logic               bid_valid;
    logic [LEVEL_W-1:0] best_bid_level;
    logic               ask_valid;
    logic [LEVEL_W-1:0] best_ask_level;
  } out_t;

  // result handoff from the control unit to the output register
  typedef struct packed {
    logic valid;
    out_t data;
  } res_t;

endpackage

/* hdl/plbt_word_ram.sv */
// one side's occupancy bitmap memory, one write and one registered read port
module plbt_word_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 64,
  parameter int AW    = 5
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/plbt_ctrl.sv */
// sequencer: read-modify-write of the bitmap word, best update and rescan
module plbt_ctrl
  import plbt_pkg::*;
#(
  parameter int LEVELS    = DEF_LEVELS,
  parameter int WORD_BITS = DEF_WORD_BITS,
  parameter int WORDS     = (LEVELS + WORD_BITS - 1) / WORD_BITS,
  parameter int AW        = (WORDS > 1) ? $clog2(WORDS) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_t                  in_data_i,
  output logic [AW-1:0]        raddr_o,
  output logic [AW-1:0]        waddr_o,
  output logic [WORD_BITS-1:0] wdata_o,
  output logic                 bid_we_o,
  output logic                 bid_re_o,
  input  logic [WORD_BITS-1:0] bid_rdata_i,
  output logic                 ask_we_o,
  output logic                 ask_re_o,
  input  logic [WORD_BITS-1:0] ask_rdata_i,
  input  logic                 res_ready_i,
  output res_t                 res_o
);

  localparam int BW = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  // reciprocal for level / WORD_BITS, exact over all LEVEL_W-bit levels
  localparam int SH  = LEVEL_W + BW;
  localparam int MUL = ((2 ** SH) + WORD_BITS - 1) / WORD_BITS;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MOD  = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  state_e               state_q, state_d;
  logic                 kind_q, kind_d;
  logic                 side_q, side_d;
  logic                 inrange_q, inrange_d;
  logic [LEVEL_W-1:0]   lvl_q, lvl_d;
  logic [AW-1:0]        widx_q, widx_d;
  logic [BW-1:0]        bidx_q, bidx_d;
  logic [AW-1:0]        scan_widx_q, scan_widx_d;
  logic                 fwd_hit_q, fwd_hit_d;
  logic [WORD_BITS-1:0] fwd_word_q, fwd_word_d;
  logic [WORDS-1:0]     bid_sum_q, bid_sum_d;
  logic [WORDS-1:0]     ask_sum_q, ask_sum_d;
  logic [LEVEL_W-1:0]   best_bid_q, best_bid_d;
  logic                 bid_ok_q, bid_ok_d;
  logic [LEVEL_W-1:0]   best_ask_q, best_ask_d;
  logic                 ask_ok_q, ask_ok_d;

  // split of the incoming level into word and bit index
  logic [31:0]          prod;
  logic [31:0]          quot;
  logic [LEVEL_W-1:0]   rem;
  logic [AW-1:0]        in_widx;
  logic [BW-1:0]        in_bidx;
  logic                 in_range;

  assign prod     = 32'(in_data_i.level_index) * 32'(MUL);
  assign quot     = prod >> SH;
  assign rem      = in_data_i.level_index - LEVEL_W'(quot * 32'(WORD_BITS));
  assign in_widx  = AW'(quot);
  assign in_bidx  = BW'(rem);
  assign in_range = 32'(in_data_i.level_index) < 32'(LEVELS);

  // modified word; a word whose summary bit is clear reads as empty
  logic [WORD_BITS-1:0] word_rd;
  logic                 word_live;
  logic [WORD_BITS-1:0] cur_word;
  logic [WORD_BITS-1:0] bit_mask;
  logic [WORD_BITS-1:0] new_word;

  assign word_rd   = side_q ? ask_rdata_i : bid_rdata_i;
  assign word_live = side_q ? ask_sum_q[widx_q] : bid_sum_q[widx_q];
  assign cur_word  = word_live ? word_rd : '0;
  assign bit_mask  = {{(WORD_BITS-1){1'b0}}, 1'b1} << bidx_q;
  assign new_word  = (kind_q == KIND_CLEAR) ? (cur_word & ~bit_mask) : (cur_word | bit_mask);

  // summary vector of the touched side after this write
  logic [WORDS-1:0] sum_new;
  always_comb begin
    sum_new         = side_q ? ask_sum_q : bid_sum_q;
    sum_new[widx_q] = |new_word;
  end

  // extreme nonzero word: highest for bids, lowest for asks
  logic [AW-1:0] sum_idx;
  logic          sum_any;
  always_comb begin
    sum_idx = '0;
    sum_any = |sum_new;
    if (side_q == SIDE_BID) begin
      for (int i = 0; i < WORDS; i++) begin
        if (sum_new[i]) sum_idx = AW'(i);
      end
    end else begin
      for (int i = WORDS - 1; i >= 0; i--) begin
        if (sum_new[i]) sum_idx = AW'(i);
      end
    end
  end

  // extreme set bit inside the rescanned word
  logic [WORD_BITS-1:0] scan_word;
  logic [BW-1:0]        scan_bit;
  logic [31:0]          scan_lvl;
  assign scan_word = fwd_hit_q ? fwd_word_q : word_rd;
  always_comb begin
    scan_bit = '0;
    if (side_q == SIDE_BID) begin
      for (int i = 0; i < WORD_BITS; i++) begin
        if (scan_word[i]) scan_bit = BW'(i);
      end
    end else begin
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
        if (scan_word[i]) scan_bit = BW'(i);
      end
    end
  end
  assign scan_lvl = 32'(scan_widx_q) * 32'(WORD_BITS) + 32'(scan_bit);

  assign in_ready_o = (state_q == ST_IDLE);

  // sequencer
  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    side_d      = side_q;
    inrange_d   = inrange_q;
    lvl_d       = lvl_q;
    widx_d      = widx_q;
    bidx_d      = bidx_q;
    scan_widx_d = scan_widx_q;
    fwd_hit_d   = fwd_hit_q;
    fwd_word_d  = fwd_word_q;
    bid_sum_d   = bid_sum_q;
    ask_sum_d   = ask_sum_q;
    best_bid_d  = best_bid_q;
    bid_ok_d    = bid_ok_q;
    best_ask_d  = best_ask_q;
    ask_ok_d    = ask_ok_q;
    raddr_o     = in_widx;
    waddr_o     = widx_q;
    wdata_o     = new_word;
    bid_we_o    = 1'b0;
    ask_we_o    = 1'b0;
    bid_re_o    = 1'b0;
    ask_re_o    = 1'b0;
    res_o.valid = 1'b0;
    // result fields come from the registered bests
    res_o.data.bid_valid      = bid_ok_q;
    res_o.data.best_bid_level = bid_ok_q ? best_bid_q : '0;
    res_o.data.ask_valid      = ask_ok_q;
    res_o.data.best_ask_level = ask_ok_q ? best_ask_q : '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          kind_d    = in_data_i.kind;
          side_d    = in_data_i.side;
          lvl_d     = in_data_i.level_index;
          inrange_d = in_range;
          widx_d    = in_widx;
          bidx_d    = in_bidx;
          bid_re_o  = (in_data_i.side == SIDE_BID);
          ask_re_o  = (in_data_i.side == SIDE_ASK);
          state_d   = ST_MOD;
        end
      end
      ST_MOD: begin
        state_d = ST_EMIT;
        if (inrange_q) begin
          // write back the word and its summary bit
          bid_we_o = (side_q == SIDE_BID);
          ask_we_o = (side_q == SIDE_ASK);
          if (side_q == SIDE_BID) begin
            bid_sum_d = sum_new;
          end else begin
            ask_sum_d = sum_new;
          end
          if (kind_q == KIND_SET) begin
            if (side_q == SIDE_BID) begin
              if (!bid_ok_q || lvl_q > best_bid_q) begin
                best_bid_d = lvl_q;
                bid_ok_d   = 1'b1;
              end
            end else begin
              if (!ask_ok_q || lvl_q < best_ask_q) begin
                best_ask_d = lvl_q;
                ask_ok_d   = 1'b1;
              end
            end
          end else if ((side_q == SIDE_BID && bid_ok_q && lvl_q == best_bid_q) ||
                       (side_q == SIDE_ASK && ask_ok_q && lvl_q == best_ask_q)) begin
            // cleared the best level: rescan or invalidate
            if (sum_any) begin
              raddr_o     = sum_idx;
              bid_re_o    = (side_q == SIDE_BID);
              ask_re_o    = (side_q == SIDE_ASK);
              scan_widx_d = sum_idx;
              fwd_hit_d   = (sum_idx == widx_q);
              fwd_word_d  = new_word;
              state_d     = ST_SCAN;
            end else if (side_q == SIDE_BID) begin
              best_bid_d = '0;
              bid_ok_d   = 1'b0;
            end else begin
              best_ask_d = '0;
              ask_ok_d   = 1'b0;
            end
          end
        end
      end
      ST_SCAN: begin
        if (side_q == SIDE_BID) begin
          best_bid_d = scan_lvl[LEVEL_W-1:0];
        end else begin
          best_ask_d = scan_lvl[LEVEL_W-1:0];
        end
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        res_o.valid = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state and bests
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      bid_sum_q  <= '0;
      ask_sum_q  <= '0;
      best_bid_q <= '0;
      bid_ok_q   <= 1'b0;
      best_ask_q <= '0;
      ask_ok_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      bid_sum_q  <= bid_sum_d;
      ask_sum_q  <= ask_sum_d;
      best_bid_q <= best_bid_d;
      bid_ok_q   <= bid_ok_d;
      best_ask_q <= best_ask_d;
      ask_ok_q   <= ask_ok_d;
    end
  end

  // transaction payload held across the sequence
  always_ff @(posedge clk_i) begin
    kind_q      <= kind_d;
    side_q      <= side_d;
    inrange_q   <= inrange_d;
    lvl_q       <= lvl_d;
    widx_q      <= widx_d;
    bidx_q      <= bidx_d;
    scan_widx_q <= scan_widx_d;
    fwd_hit_q   <= fwd_hit_d;
    fwd_word_q  <= fwd_word_d;
  end

endmodule

/* hdl/price_level_bitmap_best_tracker_top.sv */
// top level: bitmap memories, sequencer and output register
//
//   channel | direction | payload | handshake
//   in      | input     | in_t    | in_valid_i / in_stall_o
//   out     | output    | out_t   | out_valid_o / out_stall_i
//
// An event passes from acceptance through the read-modify-write state and the emit state to
// a result in the output register; clearing the best level forces a rescan (one extra
// registered memory read). The next event is accepted only once the sequencer is back in
// idle after the result is loaded, so the read-modify-write on the side's bitmap memory is done first.
// Reset clears the per-word summary bits and the bests; no memory clearing pass is needed.
// While the output register is stalled, a finished result waits in the sequencer.
module price_level_bitmap_best_tracker_top
  import plbt_pkg::*;
#(
  parameter int LEVELS    = DEF_LEVELS,
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam int WORDS = (LEVELS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

  logic                 in_ready;
  logic [AW-1:0]        raddr;
  logic [AW-1:0]        waddr;
  logic [WORD_BITS-1:0] wdata;
  logic                 bid_we, bid_re, ask_we, ask_re;
  logic [WORD_BITS-1:0] bid_rdata, ask_rdata;
  logic                 res_ready;
  res_t                 res;
  logic                 out_valid_q;
  out_t                 out_q;

  // bid side bitmap
  plbt_word_ram #(
    .DEPTH (WORDS),
    .WIDTH (WORD_BITS),
    .AW    (AW)
  ) u_bid_ram (
    .clk_i   (clk_i),
    .we_i    (bid_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (bid_re),
    .raddr_i (raddr),
    .rdata_o (bid_rdata)
  );

  // ask side bitmap
  plbt_word_ram #(
    .DEPTH (WORDS),
    .WIDTH (WORD_BITS),
    .AW    (AW)
  ) u_ask_ram (
    .clk_i   (clk_i),
    .we_i    (ask_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (ask_re),
    .raddr_i (raddr),
    .rdata_o (ask_rdata)
  );

  plbt_ctrl #(
    .LEVELS    (LEVELS),
    .WORD_BITS (WORD_BITS),
    .WORDS     (WORDS),
    .AW        (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data_i),
    .raddr_o     (raddr),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .bid_we_o    (bid_we),
    .bid_re_o    (bid_re),
    .bid_rdata_i (bid_rdata),
    .ask_we_o    (ask_we),
    .ask_re_o    (ask_re),
    .ask_rdata_i (ask_rdata),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign in_stall_o = !in_ready;
  assign res_ready  = !out_valid_q || !out_stall_i;

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (res.valid && res_ready) begin
      out_q <= res.data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* dv/testbench.sv */
// self-checking testbench for the price level bitmap best tracker
module testbench;
  import plbt_pkg::*;

  localparam int NUM_LEVELS  = DEF_LEVELS;
  localparam int IDLE_LIMIT  = 5000;
  localparam int HOLD_CYCLES = 500;
  localparam int DRAIN_WAIT  = 16;

  // clock, reset and block ports
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  // stimulus and scoreboard
  in_t  pending_events[$];
  out_t expected_books[$];
  int   error_count = 0;
  int   events_accepted = 0;
  int   results_checked = 0;
  bit   event_taken = 1'b0;
  int   send_gap = 0;
  int   stall_left = 0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;
  int   idle_cycles = 0;

  // predictor state: one occupancy map per side plus the tracked bests
  bit [NUM_LEVELS-1:0]  bid_map = '0;
  bit [NUM_LEVELS-1:0]  ask_map = '0;
  logic [LEVEL_W-1:0]   top_bid = '0;
  logic [LEVEL_W-1:0]   top_ask = '0;
  bit                   top_bid_live = 1'b0;
  bit                   top_ask_live = 1'b0;

  // generator view of occupied levels per side
  int bid_live[$];
  int ask_live[$];

  price_level_bitmap_best_tracker_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always #4 clk_i = ~clk_i;

  // apply one event to the predicted book and return both bests
  function automatic out_t apply_book_event(in_t ev);
    int   lvl;
    bit   found;
    out_t res;
    lvl = int'(ev.level_index);
    found = 1'b0;
    if (lvl < NUM_LEVELS) begin
      if (ev.side == SIDE_BID) begin
        if (ev.kind == KIND_SET) begin
          bid_map[lvl] = 1'b1;
          if (!top_bid_live || lvl > int'(top_bid)) begin
            top_bid = ev.level_index;
            top_bid_live = 1'b1;
          end
        end else begin
          bid_map[lvl] = 1'b0;
          // best bid removed: search downward for the next occupied level
          if (top_bid_live && lvl == int'(top_bid)) begin
            for (int l = NUM_LEVELS - 1; l >= 0 && !found; l--) begin
              if (bid_map[l]) begin
                top_bid = l[LEVEL_W-1:0];
                found = 1'b1;
              end
            end
            top_bid_live = found;
            if (!found) top_bid = '0;
          end
        end
      end else begin
        if (ev.kind == KIND_SET) begin
          ask_map[lvl] = 1'b1;
          if (!top_ask_live || lvl < int'(top_ask)) begin
            top_ask = ev.level_index;
            top_ask_live = 1'b1;
          end
        end else begin
          ask_map[lvl] = 1'b0;
          // best ask removed: search upward for the next occupied level
          if (top_ask_live && lvl == int'(top_ask)) begin
            for (int l = 0; l < NUM_LEVELS && !found; l++) begin
              if (ask_map[l]) begin
                top_ask = l[LEVEL_W-1:0];
                found = 1'b1;
              end
            end
            top_ask_live = found;
            if (!found) top_ask = '0;
          end
        end
      end
    end
    res.bid_valid      = top_bid_live;
    res.best_bid_level = top_bid_live ? top_bid : '0;
    res.ask_valid      = top_ask_live;
    res.best_ask_level = top_ask_live ? top_ask : '0;
    return res;
  endfunction

  // idle length for either side, with calm stretches that never idle
  function automatic int idle_len();
    int r;
    if ((events_accepted / 128) % 4 == 1) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // queue one event and keep the generator view of occupancy current
  task automatic add_event(logic kind, logic side, int lvl);
    in_t ev;
    int  idx[$];
    ev.kind = kind;
    ev.side = side;
    ev.level_index = lvl[LEVEL_W-1:0];
    pending_events = {pending_events, ev};
    if (side == SIDE_BID) begin
      idx = bid_live.find_first_index(x) with (x == lvl);
      if (kind == KIND_SET && idx.size() == 0) bid_live = {bid_live, lvl};
      if (kind == KIND_CLEAR && idx.size() != 0) bid_live.delete(idx[0]);
    end else begin
      idx = ask_live.find_first_index(x) with (x == lvl);
      if (kind == KIND_SET && idx.size() == 0) ask_live = {ask_live, lvl};
      if (kind == KIND_CLEAR && idx.size() != 0) ask_live.delete(idx[0]);
    end
  endtask

  // stimulus, reset and end of run
  initial begin
    int   target;
    int   base;
    int   span;
    int   r;
    int   lvl;
    int   live_n;
    int   ext[$];
    logic side;

    // directed: extremes, improving and non-improving sets, rescans across words
    add_event(KIND_SET,   SIDE_BID, 0);
    add_event(KIND_SET,   SIDE_ASK, 2047);
    add_event(KIND_SET,   SIDE_BID, 2047);
    add_event(KIND_SET,   SIDE_ASK, 0);
    add_event(KIND_SET,   SIDE_BID, 1000);
    add_event(KIND_SET,   SIDE_BID, 1000);
    add_event(KIND_CLEAR, SIDE_BID, 5);
    add_event(KIND_CLEAR, SIDE_BID, 1000);
    add_event(KIND_CLEAR, SIDE_BID, 2047);
    add_event(KIND_CLEAR, SIDE_BID, 0);
    add_event(KIND_CLEAR, SIDE_BID, 0);
    add_event(KIND_CLEAR, SIDE_ASK, 0);
    add_event(KIND_SET,   SIDE_ASK, 1365);
    add_event(KIND_SET,   SIDE_ASK, 682);
    add_event(KIND_CLEAR, SIDE_ASK, 682);
    add_event(KIND_CLEAR, SIDE_ASK, 1365);
    add_event(KIND_CLEAR, SIDE_ASK, 2047);
    add_event(KIND_SET,   SIDE_BID, 63);
    add_event(KIND_SET,   SIDE_BID, 64);
    add_event(KIND_CLEAR, SIDE_BID, 64);
    add_event(KIND_CLEAR, SIDE_BID, 63);
    add_event(KIND_SET,   SIDE_ASK, 64);
    add_event(KIND_SET,   SIDE_ASK, 63);
    add_event(KIND_CLEAR, SIDE_ASK, 63);
    add_event(KIND_CLEAR, SIDE_ASK, 64);

    // random episodes: each picks a price window and a target book depth
    target = 1;
    base = 0;
    span = NUM_LEVELS;
    for (int i = 0; i < 1000; i++) begin
      if (i % 40 == 0) begin
        target = $urandom_range(1, 24);
        if ($urandom_range(0, 2) == 0) begin
          base = 0;
          span = NUM_LEVELS;
        end else begin
          span = $urandom_range(8, 300);
          base = $urandom_range(0, NUM_LEVELS - span);
        end
      end
      side = $urandom_range(0, 1);
      live_n = (side == SIDE_BID) ? bid_live.size() : ask_live.size();
      lvl = base + $urandom_range(0, span - 1);
      r = $urandom_range(0, 99);
      if (r >= 90) begin
        // noise: clear a likely empty level or set one that is already occupied
        if ($urandom_range(0, 1) == 0 || live_n == 0) begin
          add_event(KIND_CLEAR, side, $urandom_range(0, NUM_LEVELS - 1));
        end else begin
          lvl = (side == SIDE_BID) ? bid_live[$urandom_range(0, live_n - 1)]
                                   : ask_live[$urandom_range(0, live_n - 1)];
          add_event(KIND_SET, side, lvl);
        end
      end else if (live_n < target && r < 70 || live_n == 0) begin
        add_event(KIND_SET, side, lvl);
      end else if (r < 60) begin
        // remove the current best of the side to force a rescan
        ext = (side == SIDE_BID) ? bid_live.max() : ask_live.min();
        add_event(KIND_CLEAR, side, ext[0]);
      end else if (r < 78) begin
        lvl = (side == SIDE_BID) ? bid_live[$urandom_range(0, live_n - 1)]
                                 : ask_live[$urandom_range(0, live_n - 1)];
        add_event(KIND_CLEAR, side, lvl);
      end else begin
        add_event(KIND_SET, side, lvl);
      end
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // wait for all events to enter and all results to come back
    while (pending_events.size() != 0 || in_valid || expected_books.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_WAIT) @(negedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // driver: presents queued events with random gaps
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || event_taken)) begin
      if (send_gap > 0 || pending_events.size() == 0) begin
        in_valid <= 1'b0;
        if (send_gap > 0) send_gap--;
      end else begin
        in_valid <= 1'b1;
        in_data <= pending_events.pop_front();
        send_gap = idle_len();
      end
    end
  end

  // receiver stall: random bursts plus one long hold-off to back up the block
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (!hold_done && results_checked >= 300) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 3) == 0) stall_left = idle_len();
    end
  end

  // input monitor: predict the result of each accepted transaction
  always @(posedge clk_i) begin
    event_taken = rst_ni && in_valid && !in_stall;
    if (event_taken) begin
      expected_books = {expected_books, apply_book_event(in_data)};
      events_accepted++;
    end
  end

  // output monitor: compare each result with the oldest prediction
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_books.size() == 0) begin
        $error("unexpected result transaction: %p", out_data);
        error_count++;
      end else begin
        want = expected_books.pop_front();
        if (out_data.bid_valid !== want.bid_valid) begin
          $error("bid_valid: expected %0d, got %0d", want.bid_valid, out_data.bid_valid);
          error_count++;
        end
        if (out_data.best_bid_level !== want.best_bid_level) begin
          $error("best_bid_level: expected %0d, got %0d",
                 want.best_bid_level, out_data.best_bid_level);
          error_count++;
        end
        if (out_data.ask_valid !== want.ask_valid) begin
          $error("ask_valid: expected %0d, got %0d", want.ask_valid, out_data.ask_valid);
          error_count++;
        end
        if (out_data.best_ask_level !== want.best_ask_level) begin
          $error("best_ask_level: expected %0d, got %0d",
                 want.best_ask_level, out_data.best_ask_level);
          error_count++;
        end
      end
      results_checked++;
    end
  end

  // watchdog: cycles with no transaction on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

endmodule
